FILE: rtl/kle_pkg.sv
// ----------------------------------------------------------------------------
// Keyframe level envelope package
// Shared widths, request and register codes, state types and the records
// passed between the sequencer and the serial interpolation unit.
// ----------------------------------------------------------------------------
package kle_pkg;

    // Field widths of the request and result items.
    localparam int REQ_W     = 2;
    localparam int INDEX_W   = 4;
    localparam int LEVEL_W   = 8;
    localparam int DUR_W     = 16;
    localparam int CHAN_W    = 2;
    localparam int COUNT_W   = 5;

    // Stream and configuration port widths.
    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = REQ_W;
    localparam int M_TDATA_W   = LEVEL_W;
    localparam int M_TUSER_W   = CHAN_W;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = COUNT_W;

    // One table entry holds a level and a duration.
    localparam int ENTRY_W = LEVEL_W + DUR_W;
    // Weighted sum of two levels over one duration.
    localparam int PROD_W  = LEVEL_W + DUR_W;
    // Step counter of the serial unit, one level bit per step.
    localparam int STEP_W  = $clog2(LEVEL_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LEVEL_W - 1);

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_KEYFRAME_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_CHANNEL  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_ENABLE  = 2'd2;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_EVAL,
        ST_CALC,
        ST_PUSH
    } t_kle_state;

    // Phases of the serial interpolation unit.
    typedef enum logic [1:0] {
        IP_IDLE,
        IP_MUL,
        IP_DIV,
        IP_FIN
    } t_interp_state;

    // Operands handed to the interpolation unit.
    typedef struct packed {
        logic [LEVEL_W-1:0] v0;
        logic [LEVEL_W-1:0] v1;
        logic [DUR_W-1:0]   dur;
        logic [DUR_W-1:0]   tick;
    } t_interp_req;

    // Result and completion flag from the interpolation unit.
    typedef struct packed {
        logic [LEVEL_W-1:0] quotient;
        logic               done;
    } t_interp_rsp;

endpackage

FILE: rtl/kle_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kle_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/kle_interp.sv
// ----------------------------------------------------------------------------
// Serial interpolation unit
// Forms v0*(dur-ti) + v1*ti by shift and add, one level bit per cycle, then
// divides by dur with a restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kle_interp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  kle_pkg::t_interp_req i_req,
    output kle_pkg::t_interp_rsp o_rsp
);
    import kle_pkg::*;

    t_interp_state       r_phase;
    t_interp_state       n_phase;
    logic [STEP_W-1:0]   r_cnt;
    logic [LEVEL_W-1:0]  r_v0_sh;
    logic [LEVEL_W-1:0]  r_v1_sh;
    logic [DUR_W-1:0]    r_a;
    logic [DUR_W-1:0]    r_ti;
    logic [DUR_W-1:0]    r_dur;
    logic [PROD_W-1:0]   r_acc;
    logic [DUR_W-1:0]    r_rem;
    logic [LEVEL_W-1:0]  r_q;

    logic [DUR_W-1:0]    n_ti;
    logic [PROD_W-1:0]   n_acc;
    logic [DUR_W:0]      w_trial;
    logic [DUR_W:0]      w_diff;
    logic                w_fits;
    logic                w_last;

    // Clamp the tick count to the duration at load time.
    assign n_ti = (i_req.tick < i_req.dur) ? i_req.tick : i_req.dur;

    // One shift-and-add step of both products.
    always_comb begin
        n_acc = {r_acc[PROD_W-2:0], 1'b0};
        if (r_v0_sh[LEVEL_W-1]) begin
            n_acc = n_acc + PROD_W'(r_a);
        end
        if (r_v1_sh[LEVEL_W-1]) begin
            n_acc = n_acc + PROD_W'(r_ti);
        end
    end

    // One restoring division step: bring down the next numerator bit.
    assign w_trial = {r_rem, r_acc[LEVEL_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_dur});
    assign w_diff  = w_trial - {1'b0, r_dur};
    assign w_last  = (r_cnt == LAST_STEP);

    // Phase sequencing.
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            IP_IDLE: begin
                if (i_start) begin
                    n_phase = IP_MUL;
                end
            end
            IP_MUL: begin
                if (w_last) begin
                    n_phase = IP_DIV;
                end
            end
            IP_DIV: begin
                if (w_last) begin
                    n_phase = IP_FIN;
                end
            end
            IP_FIN: begin
                n_phase = IP_IDLE;
            end
            default: begin
                n_phase = IP_IDLE;
            end
        endcase
    end

    // Result outputs.
    always_comb begin
        o_rsp.quotient = r_q;
        o_rsp.done     = (r_phase == IP_FIN);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= IP_IDLE;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            if (r_phase == IP_IDLE) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + STEP_W'(1);
            end
        end
    end

    // Datapath shift registers.
    always_ff @(posedge i_clk) begin
        case (r_phase)
            IP_IDLE: begin
                if (i_start) begin
                    r_v0_sh <= i_req.v0;
                    r_v1_sh <= i_req.v1;
                    r_dur   <= i_req.dur;
                    r_ti    <= n_ti;
                    r_a     <= i_req.dur - n_ti;
                    r_acc   <= '0;
                end
            end
            IP_MUL: begin
                r_v0_sh <= {r_v0_sh[LEVEL_W-2:0], 1'b0};
                r_v1_sh <= {r_v1_sh[LEVEL_W-2:0], 1'b0};
                r_acc   <= n_acc;
                // The high part of the sum is the first partial remainder.
                r_rem   <= n_acc[PROD_W-1:LEVEL_W];
            end
            IP_DIV: begin
                r_acc <= {r_acc[PROD_W-2:0], 1'b0};
                r_rem <= w_fits ? w_diff[DUR_W-1:0] : w_trial[DUR_W-1:0];
                r_q   <= {r_q[LEVEL_W-2:0], w_fits};
            end
            default: begin
            end
        endcase
    end

    // A new operation is only started while the unit is free.
    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_phase == IP_IDLE)
        else $error("interpolation started while busy");

    // The finish phase always follows the division phase.
    a_fin_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == IP_FIN |-> $past(r_phase) == IP_DIV)
        else $error("finish phase reached without division");

    // The final remainder is below the divisor.
    a_rem_below_dur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == IP_FIN |-> r_rem < r_dur)
        else $error("division remainder out of range");

endmodule

FILE: rtl/keyframe_level_envelope.sv
// ----------------------------------------------------------------------------
// Keyframe level envelope
// A piecewise linear LED fade generator for one color channel. Keyframes
// (level and duration) are loaded with write requests; each tick request
// while the envelope runs returns one result with the level interpolated as
// floor((v0*(dur-ti) + v1*ti) / dur), the last keyframe held flat, and a
// final result with level 0 and tlast set when the envelope ends. Write,
// restart and stopped-tick requests return nothing. A tick on a flat or
// finishing segment passes through the read, evaluate and push states;
// an interpolated tick also waits on the serial multiply and divide unit,
// which handles one level bit per cycle for 8 multiply steps and 8 divide
// steps. The keyframe table is a RAM read twice per tick, once for the
// current and once for the next entry.
// ----------------------------------------------------------------------------
module keyframe_level_envelope #(
    parameter int MAX_KEYFRAMES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request stream.
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // tdata: key_index[3:0], key_level[11:4], key_duration[27:12], zeros
    input  logic [kle_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [kle_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,
    // Result stream.
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // tdata: level[7:0]
    output logic [kle_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // tuser: channel[1:0]
    output logic [kle_pkg::M_TUSER_W-1:0]  o_m_axis_tuser,
    // tlast: run_done
    output logic                           o_m_axis_tlast,
    // Configuration write port.
    input  logic                           i_cfg_wr_en,
    input  logic [kle_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [kle_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import kle_pkg::*;

    localparam int AW = $clog2(MAX_KEYFRAMES);
    localparam int PW = $clog2(MAX_KEYFRAMES + 1);

    // Configuration registers.
    logic [COUNT_W-1:0]  r_keyframe_count;
    logic [CHAN_W-1:0]   r_color_channel;
    logic                r_repeat_enable;

    // Envelope state.
    t_kle_state          r_state;
    t_kle_state          n_state;
    logic [PW-1:0]       r_pos;
    logic [DUR_W-1:0]    r_tick;
    logic                r_running;

    // Current entry and pending result.
    logic [LEVEL_W-1:0]  r_v0;
    logic [DUR_W-1:0]    r_dur;
    logic [LEVEL_W-1:0]  r_res_level;
    logic                r_res_done;

    // Output register.
    logic                r_o_valid;
    logic [LEVEL_W-1:0]  r_o_level;
    logic [CHAN_W-1:0]   r_o_chan;
    logic                r_o_last;

    // Request fields.
    logic [INDEX_W-1:0]  w_key_index;
    logic [LEVEL_W-1:0]  w_key_level;
    logic [DUR_W-1:0]    w_key_dur;
    logic                w_accept;

    // Table access.
    logic                w_wr_en;
    logic [AW-1:0]       w_rd_addr;
    logic [ENTRY_W-1:0]  w_rd_data;
    logic [LEVEL_W-1:0]  w_rd_level;
    logic [DUR_W-1:0]    w_rd_dur;

    // Tick evaluation.
    logic [PW-1:0]       w_frames;
    logic [PW-1:0]       w_pos_p1;
    logic [DUR_W:0]      w_tick_next;
    logic                w_in_range;
    logic                w_advance;
    logic [PW-1:0]       w_new_pos;
    logic                w_done;
    logic                w_need_interp;

    // Sequencer outputs.
    logic                w_rd_next;
    logic                w_start;
    logic                w_out_load;

    t_interp_req         w_ireq;
    t_interp_rsp         w_irsp;

    assign w_key_index = i_s_axis_tdata[INDEX_W-1:0];
    assign w_key_level = i_s_axis_tdata[INDEX_W +: LEVEL_W];
    assign w_key_dur   = i_s_axis_tdata[INDEX_W + LEVEL_W +: DUR_W];
    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;

    // Table write on a write request with an index inside the table.
    assign w_wr_en = w_accept && (i_s_axis_tuser == REQ_WRITE)
                     && (32'(w_key_index) < MAX_KEYFRAMES);

    // Keyframe table: level in the upper bits, duration in the lower bits.
    kle_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_KEYFRAMES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(w_key_index)),
        .i_wr_data ({w_key_level, w_key_dur}),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_level = w_rd_data[ENTRY_W-1 -: LEVEL_W];
    assign w_rd_dur   = w_rd_data[DUR_W-1:0];
    assign w_rd_addr  = w_rd_next ? AW'(w_pos_p1) : AW'(r_pos);

    // Number of keyframes in use, clamped to one through the table size.
    always_comb begin
        if (r_keyframe_count == '0) begin
            w_frames = PW'(1);
        end else if (32'(r_keyframe_count) > MAX_KEYFRAMES) begin
            w_frames = PW'(MAX_KEYFRAMES);
        end else begin
            w_frames = PW'(r_keyframe_count);
        end
    end

    // Position and count update for a tick; the next entry is on the RAM
    // output while the sequencer evaluates.
    always_comb begin
        w_pos_p1      = r_pos + PW'(1);
        w_tick_next   = {1'b0, r_tick} + (DUR_W + 1)'(1);
        w_in_range    = (r_pos < w_frames);
        w_advance     = (w_tick_next >= {1'b0, r_dur});
        w_new_pos     = w_advance ? w_pos_p1 : r_pos;
        w_done        = !w_in_range || (w_new_pos >= w_frames);
        w_need_interp = !w_done && (w_pos_p1 < w_frames) && (r_dur != '0);
    end

    // Interpolation operands.
    always_comb begin
        w_ireq.v0   = r_v0;
        w_ireq.v1   = w_rd_level;
        w_ireq.dur  = r_dur;
        w_ireq.tick = r_tick;
    end

    kle_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (w_ireq),
        .o_rsp   (w_irsp)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_s_axis_tuser == REQ_TICK) && r_running) begin
                    n_state = ST_RD_A;
                end
            end
            ST_RD_A: begin
                n_state = ST_RD_B;
            end
            ST_RD_B: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_state = w_need_interp ? ST_CALC : ST_PUSH;
            end
            ST_CALC: begin
                if (w_irsp.done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);
        w_rd_next       = (r_state == ST_RD_B);
        w_start         = (r_state == ST_EVAL) && w_need_interp;
        w_out_load      = (r_state == ST_PUSH) && (!r_o_valid || i_m_axis_tready);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keyframe_count <= COUNT_W'(1);
            r_color_channel  <= '0;
            r_repeat_enable  <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_KEYFRAME_COUNT: r_keyframe_count <= i_cfg_wdata;
                REG_COLOR_CHANNEL:  r_color_channel  <= i_cfg_wdata[CHAN_W-1:0];
                REG_REPEAT_ENABLE:  r_repeat_enable  <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer state and envelope position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pos     <= '0;
            r_tick    <= '0;
            r_running <= 1'b1;
        end else begin
            r_state <= n_state;
            if (w_accept && (i_s_axis_tuser == REQ_RESTART)) begin
                r_pos     <= '0;
                r_tick    <= '0;
                r_running <= 1'b1;
            end else if (r_state == ST_EVAL) begin
                if (w_done) begin
                    r_pos     <= '0;
                    r_tick    <= '0;
                    r_running <= r_repeat_enable;
                end else if (w_advance) begin
                    r_pos  <= w_pos_p1;
                    r_tick <= '0;
                end else begin
                    r_tick <= w_tick_next[DUR_W-1:0];
                end
            end
        end
    end

    // Current entry capture and pending result.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD_B) begin
            r_v0  <= w_rd_level;
            r_dur <= w_rd_dur;
        end
        if (r_state == ST_EVAL) begin
            r_res_level <= w_done ? '0 : r_v0;
            r_res_done  <= w_done;
        end
        if ((r_state == ST_CALC) && w_irsp.done) begin
            r_res_level <= w_irsp.quotient;
        end
    end

    // Output register: valid is control, the payload loads with it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_level <= r_res_level;
            r_o_chan  <= r_color_channel;
            r_o_last  <= r_res_done;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_level;
    assign o_m_axis_tuser  = r_o_chan;
    assign o_m_axis_tlast  = r_o_last;

    // The position never runs past the table.
    a_pos_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) <= MAX_KEYFRAMES)
        else $error("keyframe position beyond table");

    // The tick count stays below the largest duration.
    a_tick_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick != '1)
        else $error("tick count overflow");

    // A finishing result always carries level zero.
    a_done_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tdata == '0)
        else $error("finishing result with nonzero level");

    // A pending result waits while the output register is still held.
    a_push_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH) && r_o_valid && !i_m_axis_tready |=> r_state == ST_PUSH)
        else $error("result dropped while output stalled");

endmodule
